FILE: src/ltf_pkg.sv
// Shared types, constants and arithmetic helpers for the two-axis tracking filter.
package ltf_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_GAIN     = 3'd0,
    REG_POSITION_GAIN = 3'd1,
    REG_BIAS_GAIN     = 3'd2,
    REG_LEAK_FACTOR   = 3'd3,
    REG_INIT_AZ       = 3'd4,
    REG_INIT_EL       = 3'd5,
    REG_INIT_AZ_BIAS  = 3'd6,
    REG_INIT_EL_BIAS  = 3'd7
  } ltf_reg_e;

  localparam logic [31:0] STEP_GAIN_RST     = 32'd21474836;
  localparam logic [31:0] POSITION_GAIN_RST = 32'd268435456;
  localparam logic [31:0] BIAS_GAIN_RST     = 32'd671089;
  localparam logic [31:0] LEAK_FACTOR_RST   = 32'd1073741824;

  // Half an LSB of a Q2.30 product, for round half away from zero
  localparam logic [64:0] RND_HALF = 65'h0_2000_0000;

  localparam logic signed [40:0] SAT_MAX = 41'sd2147483647;
  localparam logic signed [40:0] SAT_MIN = -41'sd2147483648;

  typedef struct packed {
    logic signed [31:0] meas_az;
    logic signed [31:0] meas_el;
    logic               restart;
  } ltf_in_t;

  typedef struct packed {
    logic signed [31:0] az_bias;
    logic signed [31:0] el_bias;
    logic signed [31:0] filtered_az;
    logic signed [31:0] filtered_el;
  } ltf_out_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_BL,
    OP_MUL_EB,
    OP_MUL_EK,
    OP_INNER,
    OP_MUL_T,
    OP_FILT
  } ltf_op_e;

  typedef struct packed {
    ltf_op_e op;
    logic    done;
  } ltf_cmd_t;

  // Shift a magnitude product right by 30 with rounding, then apply the sign
  function automatic logic signed [35:0] rnd_q30(logic [63:0] p, logic neg);
    logic [64:0] s;
    logic [35:0] m;
    s = {1'b0, p} + RND_HALF;
    m = {1'b0, s[64:30]};
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [40:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: src/ltf_ctrl.sv
// Sequencer that steps both axis lanes through one filter update.
module ltf_ctrl import ltf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_busy_i,
  output logic     in_stall_o,
  output ltf_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BL,
    ST_EB,
    ST_EK,
    ST_INNER,
    ST_MT,
    ST_FILT,
    ST_FIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    cmd_o.done = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_BL;
        end
      end
      ST_BL: begin
        cmd_o.op = OP_MUL_BL;
        state_d  = ST_EB;
      end
      ST_EB: begin
        cmd_o.op = OP_MUL_EB;
        state_d  = ST_EK;
      end
      ST_EK: begin
        cmd_o.op = OP_MUL_EK;
        state_d  = ST_INNER;
      end
      ST_INNER: begin
        cmd_o.op = OP_INNER;
        state_d  = ST_MT;
      end
      ST_MT: begin
        cmd_o.op = OP_MUL_T;
        state_d  = ST_FILT;
      end
      ST_FILT: begin
        cmd_o.op = OP_FILT;
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register can take the word
        if (!out_busy_i) begin
          cmd_o.done = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/ltf_lane.sv
// Datapath for one axis: error, leaky bias integrator and filtered angle.
module ltf_lane import ltf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ltf_cmd_t           cmd_i,
  input  logic signed [31:0] meas_i,
  input  logic               restart_i,
  input  logic signed [31:0] init_filt_i,
  input  logic signed [31:0] init_bias_i,
  input  logic [31:0]        step_gain_i,
  input  logic [31:0]        position_gain_i,
  input  logic [31:0]        bias_gain_i,
  input  logic [31:0]        leak_factor_i,
  output logic signed [31:0] bias_o,
  output logic signed [31:0] filt_o
);

  logic signed [31:0] bias_q, filt_q;
  logic signed [32:0] err_q;
  logic signed [35:0] acc_q, inner_q;
  logic [63:0]        prod_q;
  logic [35:0]        prodhi_q;
  logic               neg_q;

  logic signed [31:0] filt_src;
  logic signed [32:0] err_d;
  logic [31:0]        bias_mag, err_mag;
  logic [35:0]        inner_mag;
  logic [32:0]        err_abs;
  logic [31:0]        mul_a, mul_g;
  logic [63:0]        mul_p;
  logic signed [35:0] rnd;
  logic [38:0]        filt_rmag;
  logic signed [39:0] filt_r;

  assign filt_src  = restart_i ? init_filt_i : filt_q;
  assign err_d     = {meas_i[31], meas_i} - {filt_src[31], filt_src};
  assign bias_mag  = bias_q[31] ? 32'(-bias_q) : 32'(bias_q);
  assign err_abs   = err_q[32] ? 33'(-err_q) : 33'(err_q);
  assign err_mag   = err_abs[31:0];
  assign inner_mag = inner_q[35] ? 36'(-inner_q) : 36'(inner_q);

  // Share one 32x32 multiplier across the update steps
  always_comb begin
    case (cmd_i.op)
      OP_MUL_BL: begin
        mul_a = bias_mag;
        mul_g = leak_factor_i;
      end
      OP_MUL_EB: begin
        mul_a = err_mag;
        mul_g = bias_gain_i;
      end
      OP_MUL_EK: begin
        mul_a = err_mag;
        mul_g = position_gain_i;
      end
      OP_MUL_T: begin
        mul_a = inner_mag[31:0];
        mul_g = step_gain_i;
      end
      default: begin
        mul_a = err_mag;
        mul_g = position_gain_i;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_g);
  assign rnd   = rnd_q30(prod_q, neg_q);

  // High part of the product is already aligned: times 2^32 over 2^30
  assign filt_rmag = {1'b0, prodhi_q, 2'b00} + 39'(({1'b0, prod_q} + RND_HALF) >> 30);
  assign filt_r    = neg_q ? -$signed({1'b0, filt_rmag}) : $signed({1'b0, filt_rmag});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= '0;
      filt_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          if (restart_i) begin
            bias_q <= init_bias_i;
            filt_q <= init_filt_i;
          end
        end
        OP_MUL_EK: begin
          bias_q <= sat32(41'(acc_q) + 41'(rnd));
        end
        OP_FILT: begin
          filt_q <= sat32(41'(filt_q) + 41'(filt_r));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        err_q <= err_d;
      end
      OP_MUL_BL: begin
        prod_q <= mul_p;
        neg_q  <= bias_q[31];
      end
      OP_MUL_EB: begin
        prod_q <= mul_p;
        neg_q  <= err_q[32];
        acc_q  <= rnd;
      end
      OP_MUL_EK: begin
        prod_q <= mul_p;
        neg_q  <= err_q[32];
      end
      OP_INNER: begin
        inner_q <= 36'(bias_q) + rnd;
      end
      OP_MUL_T: begin
        prod_q   <= mul_p;
        prodhi_q <= 36'(inner_mag[35:32]) * 36'(step_gain_i);
        neg_q    <= inner_q[35];
      end
      default: begin
      end
    endcase
  end

  assign bias_o = bias_q;
  assign filt_o = filt_q;

endmodule

FILE: src/two_axis_leaky_tracking_filter.sv
// Top level of the two-axis leaky tracking filter: registers, lanes and output word.
//
// Each accepted word carries one azimuth and elevation sample in signed Q16.16; the
// block returns one word with both updated rate biases and both filtered angles,
// saturated to Q16.16. An update is a load, six steps in each axis lane (bias leak,
// bias error gain, position error gain, inner sum, step gain, angle update) whose
// products share the lane's single 32x32 multiplier, and a hand-off of the result
// to the output register; no new word is taken until it ends. in_stall_o stays high
// while an update runs; a finished result waits in the output register, so the
// block only holds its last step when the previous result has not been taken.
// Configuration registers are always ready and must be written while the block idles.
module two_axis_leaky_tracking_filter import ltf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ltf_in_t              in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ltf_out_t             out_word_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  logic [31:0] step_gain_q, position_gain_q, bias_gain_q, leak_factor_q;
  logic [31:0] init_az_q, init_el_q, init_az_bias_q, init_el_bias_q;

  ltf_cmd_t cmd;
  logic     out_valid_q;
  ltf_out_t out_q;
  logic     out_busy;

  logic signed [31:0] az_bias, el_bias, az_filt, el_filt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_gain_q     <= STEP_GAIN_RST;
      position_gain_q <= POSITION_GAIN_RST;
      bias_gain_q     <= BIAS_GAIN_RST;
      leak_factor_q   <= LEAK_FACTOR_RST;
      init_az_q       <= '0;
      init_el_q       <= '0;
      init_az_bias_q  <= '0;
      init_el_bias_q  <= '0;
    end else if (cfg_valid_i) begin
      case (ltf_reg_e'(cfg_index_i))
        REG_STEP_GAIN:     step_gain_q     <= cfg_data_i;
        REG_POSITION_GAIN: position_gain_q <= cfg_data_i;
        REG_BIAS_GAIN:     bias_gain_q     <= cfg_data_i;
        REG_LEAK_FACTOR:   leak_factor_q   <= cfg_data_i;
        REG_INIT_AZ:       init_az_q       <= cfg_data_i;
        REG_INIT_EL:       init_el_q       <= cfg_data_i;
        REG_INIT_AZ_BIAS:  init_az_bias_q  <= cfg_data_i;
        REG_INIT_EL_BIAS:  init_el_bias_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_busy = out_valid_q && out_stall_i;

  ltf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_busy_i (out_busy),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  ltf_lane u_lane_az (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .meas_i          (in_word_i.meas_az),
    .restart_i       (in_word_i.restart),
    .init_filt_i     ($signed(init_az_q)),
    .init_bias_i     ($signed(init_az_bias_q)),
    .step_gain_i     (step_gain_q),
    .position_gain_i (position_gain_q),
    .bias_gain_i     (bias_gain_q),
    .leak_factor_i   (leak_factor_q),
    .bias_o          (az_bias),
    .filt_o          (az_filt)
  );

  ltf_lane u_lane_el (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .meas_i          (in_word_i.meas_el),
    .restart_i       (in_word_i.restart),
    .init_filt_i     ($signed(init_el_q)),
    .init_bias_i     ($signed(init_el_bias_q)),
    .step_gain_i     (step_gain_q),
    .position_gain_i (position_gain_q),
    .bias_gain_i     (bias_gain_q),
    .leak_factor_i   (leak_factor_q),
    .bias_o          (el_bias),
    .filt_o          (el_filt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.done) begin
      out_q.az_bias     <= az_bias;
      out_q.el_bias     <= el_bias;
      out_q.filtered_az <= az_filt;
      out_q.filtered_el <= el_filt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

FILE: tb/two_axis_leaky_tracking_filter_tb.sv
// Self-checking testbench: drives angle samples, shadows the tracking update, checks each word.
`timescale 1ns / 1ps

module two_axis_leaky_tracking_filter_tb import ltf_pkg::*; ();

  localparam longint Q16_MAX = 64'sd2147483647;
  localparam longint Q16_MIN = -64'sd2147483648;
  localparam logic signed [31:0] A_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] A_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] HOLD_AZ = 32'sh1234_5678;
  localparam logic signed [31:0] HOLD_EL = 32'sh8765_4321;
  localparam logic [31:0] GAIN_MAX = 32'hFFFF_FFFF;
  localparam int PHASE_WORDS = 300;

  typedef enum logic [1:0] {
    SET_RESET,  // registers as left by reset
    SET_EDGE,   // every gain at its top, state loaded at opposite rails
    SET_HOLD    // every gain zero, so the angles freeze at the loaded values
  } setting_e;

  typedef struct packed {
    setting_e setting;
    ltf_in_t  stim;
    logic     typed;
    ltf_out_t want;
  } dir_row_t;

  localparam ltf_out_t ZERO_OUT = '0;
  localparam ltf_out_t EDGE_OUT = '{A_MAX, A_MIN, A_MAX, A_MIN};
  localparam ltf_out_t HOLD_OUT = '{32'sd0, 32'sd0, HOLD_AZ, HOLD_EL};

  localparam dir_row_t DIR_TABLE [16] = '{
    '{SET_RESET, '{32'sd0, 32'sd0, 1'b0}, 1'b1, ZERO_OUT},
    '{SET_RESET, '{32'sd0, 32'sd0, 1'b1}, 1'b1, ZERO_OUT},
    '{SET_RESET, '{A_MAX, A_MIN, 1'b0}, 1'b0, ZERO_OUT},
    '{SET_RESET, '{A_MIN, A_MAX, 1'b0}, 1'b0, ZERO_OUT},
    '{SET_RESET, '{32'sh0001_0000, 32'shFFFF_0000, 1'b0}, 1'b0, ZERO_OUT},
    '{SET_RESET, '{32'sd1, -32'sd1, 1'b1}, 1'b0, ZERO_OUT},
    '{SET_RESET, '{A_MAX, A_MAX, 1'b0}, 1'b0, ZERO_OUT},
    '{SET_RESET, '{A_MIN, A_MIN, 1'b0}, 1'b0, ZERO_OUT},
    '{SET_RESET, '{32'sh5555_5555, 32'shAAAA_AAAA, 1'b0}, 1'b0, ZERO_OUT},
    '{SET_EDGE, '{A_MAX, A_MIN, 1'b1}, 1'b1, EDGE_OUT},
    '{SET_EDGE, '{A_MIN, A_MAX, 1'b0}, 1'b0, ZERO_OUT},
    '{SET_EDGE, '{32'sd0, 32'sd0, 1'b0}, 1'b0, ZERO_OUT},
    '{SET_EDGE, '{A_MAX, A_MIN, 1'b1}, 1'b1, EDGE_OUT},
    '{SET_HOLD, '{A_MAX, A_MIN, 1'b1}, 1'b1, HOLD_OUT},
    '{SET_HOLD, '{32'sd1, -32'sd1, 1'b0}, 1'b1, HOLD_OUT},
    '{SET_HOLD, '{A_MIN, A_MAX, 1'b0}, 1'b1, HOLD_OUT}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  ltf_in_t              in_word_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  ltf_out_t             out_word_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_STEP_GAIN;
  logic [31:0]          cfg_data_i = '0;

  // Shadow of the register file and the tracker state
  logic [31:0] reg_shadow [8] = '{STEP_GAIN_RST, POSITION_GAIN_RST, BIAS_GAIN_RST,
                                  LEAK_FACTOR_RST, 32'd0, 32'd0, 32'd0, 32'd0};
  int trk_az_bias = 0;
  int trk_el_bias = 0;
  int trk_az_filt = 0;
  int trk_el_filt = 0;

  ltf_out_t predicted_states_q [$];
  int       mismatch_count = 0;
  bit       tx_calm = 1'b0;

  two_axis_leaky_tracking_filter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // round(a * g / 2^30), magnitude rounded half away from zero
  function automatic longint q30_scale(longint a, logic [31:0] g);
    logic        neg;
    logic [63:0] mag;
    logic [79:0] prod;
    neg  = (a < 0);
    mag  = neg ? -a : a;
    prod = {16'd0, mag} * {48'd0, g};
    prod = prod + (80'd1 << 29);
    mag  = prod >> 30;
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic int clamp32(longint v);
    if (v > Q16_MAX) begin
      return int'(Q16_MAX);
    end else if (v < Q16_MIN) begin
      return int'(Q16_MIN);
    end
    return int'(v);
  endfunction

  task automatic track_axis(input int meas, inout int bias, inout int filt);
    longint err;
    longint inner;
    int     nb;
    err   = longint'(meas) - longint'(filt);
    nb    = clamp32(q30_scale(bias, reg_shadow[REG_LEAK_FACTOR]) +
                    q30_scale(err, reg_shadow[REG_BIAS_GAIN]));
    // inner sum stays at full width; the new bias and the angle update saturate
    inner = longint'(nb) + q30_scale(err, reg_shadow[REG_POSITION_GAIN]);
    filt  = clamp32(longint'(filt) + q30_scale(inner, reg_shadow[REG_STEP_GAIN]));
    bias  = nb;
  endtask

  task automatic advance_tracker(input ltf_in_t s, output ltf_out_t r);
    if (s.restart) begin
      trk_az_filt = reg_shadow[REG_INIT_AZ];
      trk_el_filt = reg_shadow[REG_INIT_EL];
      trk_az_bias = reg_shadow[REG_INIT_AZ_BIAS];
      trk_el_bias = reg_shadow[REG_INIT_EL_BIAS];
    end
    track_axis(s.meas_az, trk_az_bias, trk_az_filt);
    track_axis(s.meas_el, trk_el_bias, trk_el_filt);
    r = '{trk_az_bias, trk_el_bias, trk_az_filt, trk_el_filt};
  endtask

  task automatic program_regs(input logic [31:0] step_gain, input logic [31:0] pos_gain,
                              input logic [31:0] bias_gain, input logic [31:0] leak,
                              input logic [31:0] init_az, input logic [31:0] init_el,
                              input logic [31:0] init_az_bias,
                              input logic [31:0] init_el_bias);
    logic [31:0] vals [8];
    vals[REG_STEP_GAIN]     = step_gain;
    vals[REG_POSITION_GAIN] = pos_gain;
    vals[REG_BIAS_GAIN]     = bias_gain;
    vals[REG_LEAK_FACTOR]   = leak;
    vals[REG_INIT_AZ]       = init_az;
    vals[REG_INIT_EL]       = init_el;
    vals[REG_INIT_AZ_BIAS]  = init_az_bias;
    vals[REG_INIT_EL_BIAS]  = init_el_bias;
    for (int i = 0; i < 8; i++) begin
      @(negedge clk_i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= ltf_reg_e'(i);
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      reg_shadow[i] = vals[i];
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic offer_sample(input ltf_in_t s, input logic typed, input ltf_out_t want);
    int       gap;
    ltf_out_t predicted;
    if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= s;
    do @(posedge clk_i); while (in_stall_o);
    advance_tracker(s, predicted);
    predicted_states_q = {predicted_states_q, (typed ? want : predicted)};
  endtask

  // Drop valid, wait for every word to come back, then let the pipeline settle
  task automatic await_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (predicted_states_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatch_count++;
    end
  endtask

  // Output side: random stall, one long hold-off to back the block up
  initial begin
    int       hold;
    int       taken;
    bit       rx_calm;
    ltf_out_t want;
    hold    = 0;
    taken   = 0;
    rx_calm = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (predicted_states_q.size() == 0) begin
          $error("output word with no pending expectation");
          mismatch_count++;
        end else begin
          want = predicted_states_q.pop_front();
          check_field("az_bias", want.az_bias, out_word_o.az_bias);
          check_field("el_bias", want.el_bias, out_word_o.el_bias);
          check_field("filtered_az", want.filtered_az, out_word_o.filtered_az);
          check_field("filtered_el", want.filtered_el, out_word_o.filtered_el);
        end
        taken++;
        if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
        if (taken == 150) begin
          hold = 300;
        end else begin
          hold = rx_calm ? 0 : $urandom_range(0, 15);
        end
      end
      @(negedge clk_i);
      out_stall_i <= (hold != 0);
      if (hold != 0) hold--;
    end
  end

  initial begin
    setting_e    cur_setting;
    ltf_in_t     s;
    int          pick;
    int          noise_az;
    int          noise_el;
    int          track_az;
    int          track_el;
    int          slope_az;
    int          slope_el;
    logic [31:0] g [4];
    cur_setting = SET_RESET;
    track_az    = 0;
    track_el    = 0;
    slope_az    = 0;
    slope_el    = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < $size(DIR_TABLE); i++) begin
      if (DIR_TABLE[i].setting != cur_setting) begin
        await_idle();
        cur_setting = DIR_TABLE[i].setting;
        if (cur_setting == SET_EDGE) begin
          program_regs(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, A_MIN, A_MAX, A_MAX, A_MIN);
        end else begin
          program_regs('0, '0, '0, '0, HOLD_AZ, HOLD_EL, 32'h0000_8000, 32'hFFFF_0000);
        end
      end
      offer_sample(DIR_TABLE[i].stim, DIR_TABLE[i].typed, DIR_TABLE[i].want);
    end

    for (int phase = 0; phase < 6; phase++) begin
      await_idle();
      case (phase)
        0: begin
          g = '{STEP_GAIN_RST, POSITION_GAIN_RST, BIAS_GAIN_RST, LEAK_FACTOR_RST};
        end
        2: begin
          g = '{GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX};
        end
        3: begin
          // no retention at all, moderate gains
          g = '{$urandom_range(0, 2**30), $urandom_range(0, 2**30),
                $urandom_range(0, 2**30), 32'd0};
        end
        4: begin
          // a realistic loop that actually tracks
          g = '{$urandom_range(0, 2**26), $urandom_range(0, 2**30),
                $urandom_range(0, 2**22), $urandom_range(2**30 - 2**27, 2**30)};
        end
        default: begin
          g = '{$urandom, $urandom, $urandom, $urandom};
        end
      endcase
      program_regs(g[0], g[1], g[2], g[3], $urandom, $urandom, $urandom, $urandom);

      for (int n = 0; n < PHASE_WORDS; n++) begin
        pick      = $urandom_range(0, 99);
        s.restart = 1'b0;
        if (pick < 8) begin
          s.restart = 1'b1;
          track_az  = $urandom;
          track_el  = $urandom;
          slope_az  = $urandom_range(0, 2**18);
          slope_el  = $urandom_range(0, 2**18);
          slope_az  = slope_az - 2**17;
          slope_el  = slope_el - 2**17;
        end
        if (pick < 80) begin
          // smooth target path with a little sensor noise
          noise_az  = $urandom_range(0, 2047);
          noise_el  = $urandom_range(0, 2047);
          track_az  = track_az + slope_az;
          track_el  = track_el + slope_el;
          s.meas_az = track_az + noise_az - 1024;
          s.meas_el = track_el + noise_el - 1024;
        end else begin
          s.meas_az = $urandom;
          s.meas_el = $urandom;
        end
        offer_sample(s, 1'b0, ZERO_OUT);
      end
    end

    await_idle();
    if (mismatch_count == 0) begin
      $display("two_axis_leaky_tracking_filter verification clean");
    end else begin
      $display("two_axis_leaky_tracking_filter verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("two_axis_leaky_tracking_filter verification failed");
    $finish;
  end

endmodule
